// ----- sv/fir_er_pkg.sv -----
`default_nettype none

package fir_er_pkg;

    localparam int MAX_TAPS   = 7;
    localparam int TAP_W      = 3;
    localparam int SIDE_W     = 2;
    localparam int SEEN_W     = 3;
    localparam int COEF_W     = 16;
    localparam int FRAC_W     = 15;
    localparam int ACC_GROW   = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TAP_COUNT = 3'd0,
        CFG_COEF_0    = 3'd1,
        CFG_COEF_1    = 3'd2,
        CFG_COEF_2    = 3'd3,
        CFG_COEF_3    = 3'd4,
        CFG_COEF_4    = 3'd5,
        CFG_COEF_5    = 3'd6,
        CFG_COEF_6    = 3'd7
    } cfg_idx_t;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [TAP_W-1:0]         taps_t;
    typedef logic [SIDE_W-1:0]        side_t;

    localparam taps_t TAP_COUNT_RESET = 3'd5;
    localparam coef_t COEF_ON_RESET   = 16'sd6554;
    localparam int    COEF_ON_TAPS    = 5;

    typedef struct packed {
        taps_t taps;
        side_t side;
    } tap_cfg_t;

    typedef struct packed {
        logic valid;
        logic last;
    } stage_tag_t;

endpackage

`default_nettype wire

// ----- sv/fir_er_cfg.sv -----
`default_nettype none

module fir_er_cfg
    import fir_er_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output coef_t                      coef [MAX_TAPS],
    output tap_cfg_t                   tap_cfg
);

    taps_t tap_count_reg;
    coef_t coef_reg [MAX_TAPS];
    taps_t taps;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                coef_reg[i] <= (i < COEF_ON_TAPS) ? COEF_ON_RESET : '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_TAP_COUNT: tap_count_reg <= cfg_data[TAP_W-1:0];
                default:       coef_reg[3'(cfg_addr - CFG_COEF_0)] <= cfg_data[COEF_W-1:0];
            endcase
        end
    end

    // clamp taps into 1..MAX_TAPS
    always_comb
    begin
        taps = tap_count_reg;
        if (tap_count_reg == '0)
        begin
            taps = taps_t'(1);
        end
        else if (int'(tap_count_reg) > MAX_TAPS)
        begin
            taps = taps_t'(MAX_TAPS);
        end
    end

    assign tap_cfg.taps = taps;
    assign tap_cfg.side = taps[TAP_W-1:1];
    assign coef         = coef_reg;

endmodule

`default_nettype wire

// ----- sv/fir_er_ctrl.sv -----
`default_nettype none

module fir_er_ctrl
    import fir_er_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          s_last,
    input  wire side_t                         side,
    input  wire logic                          take,
    output logic signed [SAMPLE_BITS-1:0]      win [MAX_TAPS],
    output stage_tag_t                         tag
);

    logic signed [SAMPLE_BITS-1:0] dl_reg  [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] dl_next [MAX_TAPS];
    logic [SEEN_W-1:0]             seen_reg, seen_next;
    logic [SEEN_W-1:0]             count_reg, count_next;
    side_t                         j_reg, j_next;
    logic                          flush_reg, flush_next;
    stage_tag_t                    tag_reg, tag_next;
    logic [SEEN_W:0]               reach;
    logic                          adv;

    assign adv      = !tag_reg.valid || take;
    assign s_tready = adv && !flush_reg;

    always_comb
    begin
        dl_next    = dl_reg;
        seen_next  = seen_reg;
        count_next = count_reg;
        j_next     = j_reg;
        flush_next = flush_reg;
        tag_next   = tag_reg;
        reach      = '0;
        if (adv)
        begin
            tag_next = '0;
            if (flush_reg)
            begin
                // replicate the final sample at the right edge
                for (int d = MAX_TAPS - 1; d > 0; d--)
                begin
                    dl_next[d] = dl_reg[d-1];
                end
                reach          = {1'b0, count_reg} + (SEEN_W+1)'(j_reg);
                tag_next.valid = reach >= (SEEN_W+1)'(side);
                tag_next.last  = (j_reg == side);
                if (j_reg == side)
                begin
                    flush_next = 1'b0;
                end
                else
                begin
                    j_next = j_reg + side_t'(1);
                end
            end
            else if (s_tvalid)
            begin
                if (seen_reg == '0)
                begin
                    // first sample of a vector fills the whole line
                    for (int d = 0; d < MAX_TAPS; d++)
                    begin
                        dl_next[d] = sample;
                    end
                end
                else
                begin
                    for (int d = MAX_TAPS - 1; d > 0; d--)
                    begin
                        dl_next[d] = dl_reg[d-1];
                    end
                    dl_next[0] = sample;
                end
                tag_next.valid = seen_reg >= SEEN_W'(side);
                tag_next.last  = s_last && (side == '0);
                seen_next      = (seen_reg == '1) ? seen_reg : seen_reg + SEEN_W'(1);
                if (s_last)
                begin
                    seen_next  = '0;
                    count_next = seen_reg;
                    j_next     = side_t'(1);
                    flush_next = (side != '0);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            count_reg <= '0;
            j_reg     <= '0;
            flush_reg <= 1'b0;
            tag_reg   <= '0;
        end
        else
        begin
            seen_reg  <= seen_next;
            count_reg <= count_next;
            j_reg     <= j_next;
            flush_reg <= flush_next;
            tag_reg   <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg <= dl_next;
    end

    assign win = dl_reg;
    assign tag = tag_reg;

endmodule

`default_nettype wire

// ----- sv/fir_er_mult.sv -----
`default_nettype none

module fir_er_mult
    import fir_er_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic signed [SAMPLE_BITS-1:0] win [MAX_TAPS],
    input  wire stage_tag_t                    tag_in,
    input  wire coef_t                         coef [MAX_TAPS],
    input  wire tap_cfg_t                      tap_cfg,
    input  wire logic                          take,
    output logic                               ready,
    output logic signed [SAMPLE_BITS+COEF_W-1:0] prod [MAX_TAPS],
    output stage_tag_t                         tag
);

    localparam int PW    = SAMPLE_BITS + COEF_W;
    localparam int IDX_W = $clog2(MAX_TAPS);

    logic signed [PW-1:0] prod_reg  [MAX_TAPS];
    logic signed [PW-1:0] prod_next [MAX_TAPS];
    logic [IDX_W-1:0]     idx       [MAX_TAPS];
    stage_tag_t           tag_reg;

    assign ready = !tag_reg.valid || take;

    // tap k sees the sample 2*side-k places back
    always_comb
    begin
        for (int k = 0; k < MAX_TAPS; k++)
        begin
            idx[k] = IDX_W'({tap_cfg.side, 1'b0}) - IDX_W'(k);
            if (int'(tap_cfg.taps) > k)
            begin
                prod_next[k] = PW'(coef[k] * win[idx[k]]);
            end
            else
            begin
                prod_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (ready)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;
    assign tag  = tag_reg;

endmodule

`default_nettype wire

// ----- sv/fir_er_sum.sv -----
`default_nettype none

module fir_er_sum
    import fir_er_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic signed [SAMPLE_BITS+COEF_W-1:0] prod [MAX_TAPS],
    input  wire stage_tag_t                           tag_in,
    input  wire logic                                 m_tready,
    output logic                                      ready,
    output logic [SAMPLE_BITS-1:0]                    filtered,
    output stage_tag_t                                tag
);

    localparam int PW = SAMPLE_BITS + COEF_W;
    localparam int AW = PW + ACC_GROW;
    localparam int QW = AW - FRAC_W;

    localparam logic signed [AW-1:0] HALF = AW'(1) << (FRAC_W - 1);
    localparam logic signed [QW-1:0] QMAX = QW'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [QW-1:0] QMIN = ~QMAX;

    logic signed [AW-1:0]   acc;
    logic signed [QW-1:0]   q;
    logic [SAMPLE_BITS-1:0] filtered_reg, filtered_next;
    stage_tag_t             tag_reg;

    assign ready = !tag_reg.valid || m_tready;

    // round half up, then saturate
    always_comb
    begin
        acc = HALF;
        for (int k = 0; k < MAX_TAPS; k++)
        begin
            acc = acc + AW'(prod[k]);
        end
        q = QW'(acc >>> FRAC_W);
        if (q > QMAX)
        begin
            filtered_next = QMAX[SAMPLE_BITS-1:0];
        end
        else if (q < QMIN)
        begin
            filtered_next = QMIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            filtered_next = q[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (ready)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready)
        begin
            filtered_reg <= filtered_next;
        end
    end

    assign filtered = filtered_reg;
    assign tag      = tag_reg;

endmodule

`default_nettype wire

// ----- sv/fir_filter_edge_replicate_top.sv -----
// Centered FIR smoothing filter with edge replication over sample vectors.
// One sample per cycle is accepted while s_tready is high; the result for
// sample i is built once sample i+side is taken (side = taps/2), through a
// delay-line stage, a registered bank of parallel tap multipliers and a sum,
// round and saturate stage that drives the output register. A sample with
// s_tlast set ends the vector: s_tready then stays low while the final
// sample is replayed to flush the right edge, and the last result of the
// vector carries m_tlast. Stages hold independently, so a waiting result
// does not block input until the pipeline is full. Write tap_count and the
// coefficients (signed Q1.15) through the cfg port only while idle.
`default_nettype none

module fir_filter_edge_replicate_top
    import fir_er_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,   // [SAMPLE_BITS-1:0] sample_in
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,   // [SAMPLE_BITS-1:0] filtered
    output logic                                   m_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]             cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]             cfg_data
);

    localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PW = SAMPLE_BITS + COEF_W;

    coef_t                         coef [MAX_TAPS];
    tap_cfg_t                      tap_cfg;
    logic signed [SAMPLE_BITS-1:0] win  [MAX_TAPS];
    logic signed [PW-1:0]          prod [MAX_TAPS];
    stage_tag_t                    win_tag, prod_tag, out_tag;
    logic                          mult_ready, sum_ready;
    logic [SAMPLE_BITS-1:0]        filtered;

    fir_er_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .coef     (coef),
        .tap_cfg  (tap_cfg)
    );

    fir_er_ctrl #(.SAMPLE_BITS(SAMPLE_BITS)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sample   (s_tdata[SAMPLE_BITS-1:0]),
        .s_last   (s_tlast),
        .side     (tap_cfg.side),
        .take     (mult_ready),
        .win      (win),
        .tag      (win_tag)
    );

    fir_er_mult #(.SAMPLE_BITS(SAMPLE_BITS)) u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .win      (win),
        .tag_in   (win_tag),
        .coef     (coef),
        .tap_cfg  (tap_cfg),
        .take     (sum_ready),
        .ready    (mult_ready),
        .prod     (prod),
        .tag      (prod_tag)
    );

    fir_er_sum #(.SAMPLE_BITS(SAMPLE_BITS)) u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .prod     (prod),
        .tag_in   (prod_tag),
        .m_tready (m_tready),
        .ready    (sum_ready),
        .filtered (filtered),
        .tag      (out_tag)
    );

    assign m_tvalid = out_tag.valid;
    assign m_tlast  = out_tag.last;
    assign m_tdata  = DW'(filtered);

endmodule

`default_nettype wire

// ----- sv/fir_er_checker.sv -----
`default_nettype none

module fir_er_checker
    import fir_er_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input  wire logic                             s_tlast,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    input  wire logic                             m_tlast,
    input  wire logic                             cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]            cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]            cfg_data
);

    taps_t tap_count_reg;
    logic  in_xfer;

    assign in_xfer = s_tvalid && s_tready && (s_tdata == s_tdata);

    // track the tap count as written on the cfg port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
        end
        else if (cfg_we && (cfg_idx_t'(cfg_addr) == CFG_TAP_COUNT))
        begin
            tap_count_reg <= cfg_data[TAP_W-1:0];
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid right after reset");

    a_flush_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && s_tlast && (tap_count_reg >= taps_t'(2)) |=> !s_tready)
        else $error("input taken during right-edge flush");

endmodule

bind fir_filter_edge_replicate_top fir_er_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (.*);

`default_nettype wire

// ----- verif/fir_filter_edge_replicate_top_test.sv -----
module fir_filter_edge_replicate_top_test;
    import fir_er_pkg::*;

    localparam int SAMPLE_BITS   = 16;
    localparam int DATA_W        = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 31;
    localparam int PRINT_CAP     = 50;

    typedef logic signed [SAMPLE_BITS-1:0] smp_t;

    typedef struct {
        smp_t filtered;
        logic last;
    } smooth_out_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic                  cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    taps_t       tap_reg;
    coef_t       coef_reg [MAX_TAPS];
    smp_t        line_reg [MAX_TAPS];
    int unsigned seen_cnt;

    smooth_out_t pending_smooth [$];
    smooth_out_t head_out;

    bit tx_free = 1'b0;
    bit rx_free = 1'b0;
    int rx_hold = 0;

    int mismatch_count  = 0;
    int samples_sent    = 0;
    int vectors_sent    = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int cycle_count     = 0;

    always #5 clk = ~clk;

    fir_filter_edge_replicate_top #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    function automatic int idle_len(input bit free);
        int r;
        if (free)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int taps_active();
        int t;
        t = tap_reg;
        if (t == 0)
        begin
            t = 1;
        end
        if (t > MAX_TAPS)
        begin
            t = MAX_TAPS;
        end
        return t;
    endfunction

    function automatic smp_t smooth_point();
        int     t;
        int     side;
        int     idx;
        longint acc;
        longint r;
        t    = taps_active();
        side = t / 2;
        acc  = 0;
        for (int k = 0; k < t; k++)
        begin
            idx = 2 * side - k;
            if (idx >= 0 && idx < MAX_TAPS)
            begin
                acc += longint'(coef_reg[k]) * longint'(line_reg[idx]);
            end
        end
        // round half up, floor divide by 2^15
        r = (acc + 64'sd16384) >>> FRAC_W;
        if (r < -(64'sd1 <<< (SAMPLE_BITS - 1)))
        begin
            r = -(64'sd1 <<< (SAMPLE_BITS - 1));
        end
        if (r > (64'sd1 <<< (SAMPLE_BITS - 1)) - 1)
        begin
            r = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
        end
        return r[SAMPLE_BITS-1:0];
    endfunction

    function automatic void shift_line(input smp_t smp);
        for (int d = MAX_TAPS - 1; d > 0; d--)
        begin
            line_reg[d] = line_reg[d - 1];
        end
        line_reg[0] = smp;
    endfunction

    function automatic void queue_smooth();
        smooth_out_t item;
        item.filtered = smooth_point();
        item.last     = 1'b0;
        pending_smooth.push_back(item);
    endfunction

    function automatic void advance_filter(input smp_t smp, input logic fin);
        int side;
        int count;
        side  = taps_active() / 2;
        count = seen_cnt;
        if (count == 0)
        begin
            // first sample of a vector replicates the left edge
            for (int d = 0; d < MAX_TAPS; d++)
            begin
                line_reg[d] = smp;
            end
        end
        else
        begin
            shift_line(smp);
        end
        if (count >= side)
        begin
            queue_smooth();
        end
        seen_cnt = (count < 7) ? count + 1 : 7;
        if (fin)
        begin
            // replay the final sample to replicate the right edge
            for (int j = 1; j <= side; j++)
            begin
                shift_line(smp);
                if (count + j >= side)
                begin
                    queue_smooth();
                end
            end
            if (pending_smooth.size() > 0)
            begin
                pending_smooth[pending_smooth.size() - 1].last = 1'b1;
            end
            seen_cnt = 0;
        end
    endfunction

    function automatic void reset_model();
        tap_reg = TAP_COUNT_RESET;
        for (int i = 0; i < MAX_TAPS; i++)
        begin
            coef_reg[i] = (i < COEF_ON_TAPS) ? COEF_ON_RESET : coef_t'(0);
            line_reg[i] = '0;
        end
        seen_cnt = 0;
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("MISMATCH: %s", msg);
        end
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_smooth.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result %h last %b", m_tdata, m_tlast));
            end
            else
            begin
                head_out = pending_smooth.pop_front();
                if (m_tdata[SAMPLE_BITS-1:0] !== head_out.filtered)
                begin
                    note_mismatch($sformatf("result %0d: filtered %h, want %h",
                                            results_checked, m_tdata, head_out.filtered));
                end
                if (m_tlast !== head_out.last)
                begin
                    note_mismatch($sformatf("result %0d: last %b, want %b",
                                            results_checked, m_tlast, head_out.last));
                end
                results_checked++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else
        begin
            rx_hold = idle_len(rx_free);
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_smooth.size());
        $display("fir_filter_edge_replicate_top: mismatch");
        $finish;
    end

    task automatic send_sample(input smp_t smp, input logic fin);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(smp);
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        advance_filter(smp, fin);
        samples_sent++;
        if (fin)
        begin
            vectors_sent++;
        end
        gap = idle_len(tx_free);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // hold input until every expected transaction is out and the pipeline is empty
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_smooth.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TAP_COUNT)
        begin
            tap_reg = value[TAP_W-1:0];
        end
        else
        begin
            coef_reg[int'(idx) - 1] = value;
        end
        reg_writes++;
    endtask

    task automatic load_config(input taps_t taps, input coef_t coef);
        settle();
        write_reg(CFG_TAP_COUNT, CFG_DATA_W'(taps));
        for (int c = 0; c < MAX_TAPS; c++)
        begin
            write_reg(cfg_idx_t'(c + 1), coef);
        end
    endtask

    function automatic smp_t pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return smp_t'($urandom);
        end
        if (r < 80)
        begin
            return smp_t'($urandom_range(0, 2000) - 1000);
        end
        case ($urandom_range(0, 4))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return 16'sh0001;
        endcase
    endfunction

    function automatic coef_t pick_coef(input int mode);
        if (mode == 0)
        begin
            return coef_t'($urandom);
        end
        if (mode == 1)
        begin
            return coef_t'($urandom_range(0, 9362) - 4681);
        end
        return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endfunction

    task automatic test_reset_defaults();
        send_sample(16'sh7fff, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'shffff, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'sd12345, 1'b1);
    endtask

    task automatic test_tap_extremes();
        // zero taps act as a single tap
        load_config(3'd0, 16'sh7fff);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b1);
        // full width, most negative coefficients: saturate high
        load_config(3'd7, 16'sh8000);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd5, 1'b1);
        // half coefficient: exact halves round up
        load_config(3'd1, 16'sd16384);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd3, 1'b1);
    endtask

    task automatic test_short_vectors();
        load_config(3'd7, 16'sd4681);
        send_sample(16'sd100, 1'b1);
        send_sample(-16'sd200, 1'b0);
        send_sample(16'sd300, 1'b1);
    endtask

    task automatic test_tap_change_mid_vector();
        load_config(3'd3, 16'sd10923);
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd3000, 1'b0);
        send_sample(16'sd7000, 1'b0);
        settle();
        write_reg(CFG_TAP_COUNT, CFG_DATA_W'(3'd7));
        send_sample(16'sd20000, 1'b0);
        send_sample(-16'sd20000, 1'b1);
    endtask

    task automatic test_random_traffic();
        taps_t taps;
        int    sent;
        int    len;
        bit    paused;
        for (int p = 0; p < 8; p++)
        begin
            taps = taps_t'((p * 5 + 1) % 8);
            settle();
            write_reg(CFG_TAP_COUNT, CFG_DATA_W'(taps));
            for (int c = 0; c < MAX_TAPS; c++)
            begin
                write_reg(cfg_idx_t'(c + 1), pick_coef(p % 3));
            end
            tx_free = (p == 2);
            rx_free = (p == 2 || p == 5);
            sent    = 0;
            paused  = 1'b0;
            while (sent < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 20);
                if (len > PHASE_ITEMS - sent)
                begin
                    len = PHASE_ITEMS - sent;
                end
                for (int i = 0; i < len; i++)
                begin
                    send_sample(pick_sample(), i == len - 1);
                end
                sent += len;
                if (p == 4 && !paused && sent >= PHASE_ITEMS / 2)
                begin
                    settle();
                    paused = 1'b1;
                end
            end
        end
        tx_free = 1'b0;
        rx_free = 1'b0;
    endtask

    initial
    begin
        reset_model();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_tap_extremes();
        test_short_vectors();
        test_tap_change_mid_vector();
        test_random_traffic();
        settle();
        $display("covered %0d samples in %0d vectors, %0d filtered results checked",
                 samples_sent, vectors_sent, results_checked);
        $display("tap counts 0 to 7, %0d register writes including coefficient extremes",
                 reg_writes);
        if (mismatch_count == 0)
        begin
            $display("fir_filter_edge_replicate_top: match");
        end
        else
        begin
            $display("fir_filter_edge_replicate_top: mismatch");
        end
        $finish;
    end

endmodule
